// ===== rtl/core/iee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_pkg
// shared types and constants for the infix expression evaluator
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] OP_PAREN = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_MALFORMED = 2'd2;
    localparam logic [1:0] ERR_DIVZERO   = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } iee_in_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic [1:0]         error;
    } iee_out_t;

    typedef struct packed {
        logic                   start;
        logic [2:0]             op;
        logic [VALUE_WIDTH-1:0] a;
        logic [VALUE_WIDTH-1:0] b;
    } iee_alu_req_t;

    function automatic logic [1:0] op_rank(input logic [2:0] op);
        logic [1:0] r;
        begin
            r = 2'((op + 3'd1) >> 1);
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/iee_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/iee_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_alu
// add, subtract, multiply and bit-serial truncating divide
// ----------------------------------------------------------------------------
module iee_alu
    import iee_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  iee_alu_req_t           req,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] res,
    output logic                   div_zero
);

    localparam int STEP_W = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] dsr_reg;
    logic                   neg_reg;
    logic                   done_reg;
    logic [VALUE_WIDTH-1:0] res_reg;
    logic                   dz_reg;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] rem_sh;
    logic [VALUE_WIDTH-1:0] ma;
    logic [VALUE_WIDTH-1:0] mb;

    assign ma     = req.a[VALUE_WIDTH-1] ? (~req.a + 1'b1) : req.a;
    assign mb     = req.b[VALUE_WIDTH-1] ? (~req.b + 1'b1) : req.b;
    assign rem_sh = {rem_reg[VALUE_WIDTH-2:0], quo_reg[VALUE_WIDTH-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                if (step_reg == STEP_W'(VALUE_WIDTH))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (req.start)
            begin
                if (req.op == OP_DIV && req.b != '0)
                begin
                    busy_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (step_reg == STEP_W'(VALUE_WIDTH))
            begin
                res_reg <= neg_reg ? (~quo_reg + 1'b1) : quo_reg;
            end
            else
            begin
                step_reg <= step_reg + 1'b1;
                if (!trial[VALUE_WIDTH])
                begin
                    rem_reg <= trial[VALUE_WIDTH-1:0];
                    quo_reg <= {quo_reg[VALUE_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[VALUE_WIDTH-2:0], 1'b0};
                end
            end
        end
        else if (req.start)
        begin
            dz_reg   <= 1'b0;
            step_reg <= '0;
            quo_reg  <= ma;
            rem_reg  <= '0;
            dsr_reg  <= mb;
            neg_reg  <= req.a[VALUE_WIDTH-1] ^ req.b[VALUE_WIDTH-1];
            case (req.op)
                OP_ADD:  res_reg <= req.a + req.b;
                OP_SUB:  res_reg <= req.a - req.b;
                OP_MUL:  res_reg <= VALUE_WIDTH'(req.a * req.b);
                OP_DIV:
                begin
                    res_reg <= '0;
                    dz_reg  <= (req.b == '0);
                end
                default: res_reg <= '0;
            endcase
        end
    end

    assign done     = done_reg;
    assign res      = res_reg;
    assign div_zero = dz_reg;

endmodule

// ===== rtl/core/iee_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_ctrl
// sequencer over value and operator stack memories
// ----------------------------------------------------------------------------
module iee_ctrl
    import iee_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  iee_in_t      in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output iee_out_t     out_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLOSE  = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_OPRD   = 4'd3;
    localparam logic [3:0] S_OPCHK  = 4'd4;
    localparam logic [3:0] S_BRD    = 4'd5;
    localparam logic [3:0] S_ARD    = 4'd6;
    localparam logic [3:0] S_AWAIT  = 4'd7;
    localparam logic [3:0] S_ALU    = 4'd8;
    localparam logic [3:0] S_PUSHR  = 4'd9;
    localparam logic [3:0] S_FINRD  = 4'd10;
    localparam logic [3:0] S_FINOUT = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    // mode: what the reduction loop is working for
    localparam logic [1:0] M_OP    = 2'd0;
    localparam logic [1:0] M_CLOSE = 2'd1;
    localparam logic [1:0] M_END   = 2'd2;

    logic [3:0]             state_reg;
    logic [1:0]             mode_reg;
    logic [7:0]             ch_reg;
    logic                   last_reg;
    logic [2:0]             op_reg;
    logic [2:0]             top_op_reg;
    logic [CNT_W-1:0]       vcnt_reg;
    logic [CNT_W-1:0]       ocnt_reg;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic                   open_reg;
    logic [1:0]             err_reg;
    logic [VALUE_WIDTH-1:0] b_reg;
    iee_out_t               out_reg;

    logic                   v_we;
    logic [PTR_W-1:0]       v_addr;
    logic [VALUE_WIDTH-1:0] v_wdata;
    logic [VALUE_WIDTH-1:0] v_rdata;
    logic                   o_we;
    logic [PTR_W-1:0]       o_addr;
    logic [2:0]             o_wdata;
    logic [2:0]             o_rdata;

    iee_alu_req_t           alu_req;
    logic                   alu_done;
    logic [VALUE_WIDTH-1:0] alu_res;
    logic                   alu_dz;

    logic                   is_digit;
    logic                   is_op;
    logic [2:0]             ch_op;
    logic [VALUE_WIDTH-1:0] acc_x10;

    iee_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_vram (
        .clk   (clk),
        .we    (v_we),
        .addr  (v_addr),
        .wdata (v_wdata),
        .rdata (v_rdata)
    );

    iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_oram (
        .clk   (clk),
        .we    (o_we),
        .addr  (o_addr),
        .wdata (o_wdata),
        .rdata (o_rdata)
    );

    iee_alu u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (alu_req),
        .done     (alu_done),
        .res      (alu_res),
        .div_zero (alu_dz)
    );

    assign is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign acc_x10  = (acc_reg << 3) + (acc_reg << 1);

    always_comb
    begin
        is_op = 1'b1;
        ch_op = OP_ADD;
        case (ch_reg)
            CH_PLUS:  ch_op = OP_ADD;
            CH_MINUS: ch_op = OP_SUB;
            CH_STAR:  ch_op = OP_MUL;
            CH_SLASH: ch_op = OP_DIV;
            default:  is_op = 1'b0;
        endcase
    end

    // memory port and alu request control
    always_comb
    begin
        v_we    = 1'b0;
        v_addr  = vcnt_reg[PTR_W-1:0];
        v_wdata = acc_reg;
        o_we    = 1'b0;
        o_addr  = ocnt_reg[PTR_W-1:0] - 1'b1;
        o_wdata = op_reg;
        alu_req = '0;
        case (state_reg)
            S_CLOSE:
            begin
                v_we = open_reg && (vcnt_reg < CNT_W'(STACK_DEPTH));
            end
            S_DISP:
            begin
                o_addr  = ocnt_reg[PTR_W-1:0];
                o_wdata = (ch_reg == CH_OPEN) ? OP_PAREN : op_reg;
                o_we    = !is_digit && (ch_reg == CH_OPEN)
                          && (ocnt_reg < CNT_W'(STACK_DEPTH));
            end
            S_OPRD:
            begin
                o_addr = ocnt_reg[PTR_W-1:0] - 1'b1;
            end
            S_OPCHK:
            begin
                o_addr  = ocnt_reg[PTR_W-1:0];
                o_we    = (mode_reg == M_OP) && (ocnt_reg == '0 ||
                          op_rank(o_rdata) < op_rank(op_reg))
                          && (ocnt_reg < CNT_W'(STACK_DEPTH));
                v_addr  = vcnt_reg[PTR_W-1:0] - 1'b1;
            end
            S_BRD:
            begin
                v_addr = vcnt_reg[PTR_W-1:0] - 1'b1;
            end
            S_ARD:
            begin
                v_addr = vcnt_reg[PTR_W-1:0] - 2'd2;
            end
            S_AWAIT:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = top_op_reg;
                alu_req.a     = v_rdata;
                alu_req.b     = b_reg;
            end
            S_PUSHR:
            begin
                v_addr  = vcnt_reg[PTR_W-1:0];
                v_wdata = alu_res;
                v_we    = 1'b1;
            end
            S_FINRD:
            begin
                v_addr = vcnt_reg[PTR_W-1:0] - 1'b1;
            end
            default:
            begin
                v_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vcnt_reg  <= '0;
            ocnt_reg  <= '0;
            acc_reg   <= '0;
            open_reg  <= 1'b0;
            err_reg   <= ERR_NONE;
            mode_reg  <= M_OP;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ch_reg    <= in_data.ch;
                        last_reg  <= in_data.last;
                        state_reg <= S_CLOSE;
                    end
                end
                S_CLOSE:
                begin
                    op_reg <= ch_op;
                    if (is_digit)
                    begin
                        acc_reg   <= acc_x10 + VALUE_WIDTH'(ch_reg - CH_ZERO);
                        open_reg  <= 1'b1;
                        state_reg <= last_reg ? S_CLOSE : S_IDLE;
                        if (last_reg)
                        begin
                            ch_reg <= 8'h00;
                        end
                    end
                    else
                    begin
                        if (open_reg)
                        begin
                            if (vcnt_reg < CNT_W'(STACK_DEPTH))
                            begin
                                vcnt_reg <= vcnt_reg + 1'b1;
                            end
                            else if (err_reg == ERR_NONE)
                            begin
                                err_reg <= ERR_OVERFLOW;
                            end
                            acc_reg  <= '0;
                            open_reg <= 1'b0;
                        end
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    if (last_reg && ch_reg == 8'h00)
                    begin
                        mode_reg  <= M_END;
                        state_reg <= S_OPRD;
                    end
                    else if (ch_reg == CH_OPEN)
                    begin
                        if (ocnt_reg < CNT_W'(STACK_DEPTH))
                        begin
                            ocnt_reg <= ocnt_reg + 1'b1;
                        end
                        else if (err_reg == ERR_NONE)
                        begin
                            err_reg <= ERR_OVERFLOW;
                        end
                        state_reg <= last_reg ? S_OPRD : S_IDLE;
                        mode_reg  <= M_END;
                    end
                    else if (ch_reg == CH_CLOSE)
                    begin
                        mode_reg  <= M_CLOSE;
                        state_reg <= S_OPRD;
                    end
                    else if (is_op)
                    begin
                        mode_reg  <= M_OP;
                        state_reg <= S_OPRD;
                    end
                    else
                    begin
                        mode_reg  <= M_END;
                        state_reg <= last_reg ? S_OPRD : S_IDLE;
                    end
                end
                S_OPRD:
                begin
                    state_reg <= S_OPCHK;
                end
                S_OPCHK:
                begin
                    top_op_reg <= o_rdata;
                    case (mode_reg)
                        M_OP:
                        begin
                            if (ocnt_reg != '0 && op_rank(o_rdata) >= op_rank(op_reg))
                            begin
                                ocnt_reg  <= ocnt_reg - 1'b1;
                                state_reg <= S_BRD;
                            end
                            else
                            begin
                                if (ocnt_reg < CNT_W'(STACK_DEPTH))
                                begin
                                    ocnt_reg <= ocnt_reg + 1'b1;
                                end
                                else if (err_reg == ERR_NONE)
                                begin
                                    err_reg <= ERR_OVERFLOW;
                                end
                                state_reg <= last_reg ? S_OPRD : S_IDLE;
                                mode_reg  <= M_END;
                            end
                        end
                        M_CLOSE:
                        begin
                            if (ocnt_reg == '0)
                            begin
                                if (err_reg == ERR_NONE)
                                begin
                                    err_reg <= ERR_MALFORMED;
                                end
                                state_reg <= last_reg ? S_OPRD : S_IDLE;
                                mode_reg  <= M_END;
                            end
                            else if (o_rdata == OP_PAREN)
                            begin
                                ocnt_reg  <= ocnt_reg - 1'b1;
                                state_reg <= last_reg ? S_OPRD : S_IDLE;
                                mode_reg  <= M_END;
                            end
                            else
                            begin
                                ocnt_reg  <= ocnt_reg - 1'b1;
                                state_reg <= S_BRD;
                            end
                        end
                        default:
                        begin
                            if (ocnt_reg == '0)
                            begin
                                state_reg <= S_FINRD;
                            end
                            else if (o_rdata == OP_PAREN)
                            begin
                                ocnt_reg <= ocnt_reg - 1'b1;
                                if (err_reg == ERR_NONE)
                                begin
                                    err_reg <= ERR_MALFORMED;
                                end
                                state_reg <= S_OPRD;
                            end
                            else
                            begin
                                ocnt_reg  <= ocnt_reg - 1'b1;
                                state_reg <= S_BRD;
                            end
                        end
                    endcase
                end
                S_BRD:
                begin
                    if (vcnt_reg < CNT_W'(2))
                    begin
                        if (err_reg == ERR_NONE)
                        begin
                            err_reg <= ERR_MALFORMED;
                        end
                        state_reg <= S_OPRD;
                    end
                    else
                    begin
                        state_reg <= S_ARD;
                    end
                end
                S_ARD:
                begin
                    b_reg     <= v_rdata;
                    state_reg <= S_AWAIT;
                end
                S_AWAIT:
                begin
                    vcnt_reg  <= vcnt_reg - 2'd2;
                    state_reg <= S_ALU;
                end
                S_ALU:
                begin
                    if (alu_done)
                    begin
                        if (alu_dz && err_reg == ERR_NONE)
                        begin
                            err_reg <= ERR_DIVZERO;
                        end
                        state_reg <= S_PUSHR;
                    end
                end
                S_PUSHR:
                begin
                    vcnt_reg  <= vcnt_reg + 1'b1;
                    state_reg <= S_OPRD;
                end
                S_FINRD:
                begin
                    state_reg <= S_FINOUT;
                end
                S_FINOUT:
                begin
                    if (err_reg != ERR_NONE)
                    begin
                        out_reg.error  <= err_reg;
                        out_reg.result <= '0;
                    end
                    else if (vcnt_reg != CNT_W'(1))
                    begin
                        out_reg.error  <= ERR_MALFORMED;
                        out_reg.result <= '0;
                    end
                    else
                    begin
                        out_reg.error  <= ERR_NONE;
                        out_reg.result <= v_rdata;
                    end
                    vcnt_reg  <= '0;
                    ocnt_reg  <= '0;
                    acc_reg   <= '0;
                    open_reg  <= 1'b0;
                    err_reg   <= ERR_NONE;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/infix_expression_evaluator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top
// shunting-yard evaluator over value and operator stack memories
//
//   channel   direction  payload            handshake
//   in        input      ch, last           in_valid / in_ready
//   out       output     result, error      out_valid / out_ready
//
// a digit is accumulated in the close state; other characters go to dispatch
// operators read the stack top; reductions use the alu (divide is bit-serial)
// the final character adds the drain, one register read and the output
// reset is asynchronous and empties both stacks by clearing their counts
// the result waits in its register until out_ready; input is held off meanwhile
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top
    import iee_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  iee_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output iee_out_t out_data
);

    iee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error != ERR_NONE) |-> (out_data.result == '0))
        else $error("nonzero result with error");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped before transfer");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// randomized check of the infix expression evaluator: a queue-fed driver
// sends expression characters in bursts, a stalling monitor compares each
// result transfer against a shunting-yard predictor kept in the bench
// ----------------------------------------------------------------------------
module testbench;
    import iee_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    iee_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    iee_out_t out_data;

    infix_expression_evaluator_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #10 clk = ~clk;

    // bench copy of the evaluator state
    logic [31:0] vals [STACK_DEPTH];
    logic [2:0]  ops [STACK_DEPTH];
    int          nvals;
    int          nops;
    logic [31:0] accum;
    bit          open_num;
    logic [1:0]  sticky;

    iee_in_t  char_queue [$];
    iee_out_t result_queue [$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       exprs_sent = 0;
    int       items_added = 0;
    int       hold_off = 0;
    bit       long_stall_done = 1'b0;
    bit       pause_req = 1'b0;
    bit       stim_done = 1'b0;
    int       gap = 0;
    int       burst = 0;

    function automatic void note_err(logic [1:0] e);
        if (sticky == ERR_NONE)
            sticky = e;
    endfunction

    function automatic void push_val(logic [31:0] v);
        if (nvals >= STACK_DEPTH)
            note_err(ERR_OVERFLOW);
        else
        begin
            vals[nvals] = v;
            nvals++;
        end
    endfunction

    function automatic void push_op(logic [2:0] o);
        if (nops >= STACK_DEPTH)
            note_err(ERR_OVERFLOW);
        else
        begin
            ops[nops] = o;
            nops++;
        end
    endfunction

    function automatic logic [1:0] prec(logic [2:0] o);
        return 2'((o + 3'd1) >> 1);
    endfunction

    function automatic void apply_top();
        logic [2:0]         o;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]        r;
        nops--;
        o = ops[nops];
        if (nvals < 2)
        begin
            note_err(ERR_MALFORMED);
            return;
        end
        b = vals[nvals-1];
        a = vals[nvals-2];
        nvals -= 2;
        case (o)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV:
            begin
                if (b == 0)
                begin
                    note_err(ERR_DIVZERO);
                    r = '0;
                end
                else if (a == 32'sh80000000 && b == -1)
                    r = a;
                else
                    r = a / b;
            end
            default: r = '0;
        endcase
        push_val(r);
    endfunction

    function automatic void close_num();
        if (open_num)
        begin
            push_val(accum);
            accum = '0;
            open_num = 1'b0;
        end
    endfunction

    function automatic void clear_eval();
        nvals = 0;
        nops = 0;
        accum = '0;
        open_num = 1'b0;
        sticky = ERR_NONE;
    endfunction

    function automatic void eval_char(iee_in_t it);
        logic [2:0] o;
        bit         is_op;
        iee_out_t   res;
        is_op = 1'b1;
        o = OP_PAREN;
        if (it.ch >= CH_ZERO && it.ch <= CH_NINE)
        begin
            accum = accum * 32'd10 + 32'(it.ch - CH_ZERO);
            open_num = 1'b1;
        end
        else
        begin
            close_num();
            case (it.ch)
                CH_PLUS:  o = OP_ADD;
                CH_MINUS: o = OP_SUB;
                CH_STAR:  o = OP_MUL;
                CH_SLASH: o = OP_DIV;
                default:  is_op = 1'b0;
            endcase
            if (it.ch == CH_OPEN)
                push_op(OP_PAREN);
            else if (it.ch == CH_CLOSE)
            begin
                while (nops > 0 && ops[nops-1] != OP_PAREN)
                    apply_top();
                if (nops > 0)
                    nops--;
                else
                    note_err(ERR_MALFORMED);
            end
            else if (is_op)
            begin
                while (nops > 0 && prec(ops[nops-1]) >= prec(o))
                    apply_top();
                push_op(o);
            end
        end
        if (!it.last)
            return;
        close_num();
        while (nops > 0)
        begin
            if (ops[nops-1] == OP_PAREN)
            begin
                nops--;
                note_err(ERR_MALFORMED);
            end
            else
                apply_top();
        end
        if (nvals != 1)
            note_err(ERR_MALFORMED);
        res.result = (nvals > 0) ? vals[nvals-1] : '0;
        res.error = sticky;
        if (sticky != ERR_NONE)
            res.result = '0;
        result_queue.push_back(res);
        clear_eval();
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            eval_char(in_data);
            if (in_data.last)
                exprs_sent++;
        end
        if (!(in_valid && !in_ready))
        begin
            if (gap > 0)
            begin
                gap <= gap - 1;
                in_valid <= 1'b0;
            end
            else if (char_queue.size() > 0 && !(pause_req && result_queue.size() > 0))
            begin
                in_data <= char_queue.pop_front();
                in_valid <= 1'b1;
                if (burst <= 0)
                begin
                    burst <= $urandom_range(1, 40);
                    if ($urandom_range(0, 2) == 0)
                        gap <= $urandom_range(1, 12);
                end
                else
                    burst <= burst - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver stall while the sender keeps offering
    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
        else if (!long_stall_done && exprs_sent >= 30)
        begin
            hold_off <= 400;
            long_stall_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (result_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %0d err %0d",
                             out_data.result, out_data.error);
            end
            else
            begin
                iee_out_t want;
                want = result_queue.pop_front();
                if (want.result !== out_data.result || want.error !== out_data.error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d err %0d, got %0d err %0d",
                                 want.result, want.error, out_data.result,
                                 out_data.error);
                end
            end
        end
        if (hold_off > 0)
            out_ready <= 1'b0;
        else if (results_seen % 7 < 3)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    function automatic void add_char(logic [7:0] c, bit l);
        iee_in_t it;
        it.ch = c;
        it.last = l;
        char_queue.push_back(it);
        items_added++;
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1);
    endfunction

    function automatic void add_num(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], 1'b0);
    endfunction

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // well-formed expression with random nesting and operands
    function automatic void add_expr(int depth);
        int terms;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++)
        begin
            if (t > 0)
                add_char(pick_op(), 1'b0);
            if (depth < 3 && $urandom_range(0, 3) == 0)
            begin
                add_char(CH_OPEN, 1'b0);
                add_expr(depth + 1);
                add_char(CH_CLOSE, 1'b0);
            end
            else if ($urandom_range(0, 9) == 0)
                add_num($urandom());
            else
                add_num($urandom_range(0, 99));
        end
    endfunction

    function automatic void end_expr();
        add_char($urandom_range(0, 1) ? 8'h20 : 8'h3b, 1'b1);
    endfunction

    initial
    begin
        int n;
        clear_eval();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // directed part
        add_str("2+3*4");
        add_str("(2+3)*4");
        add_str("7/0");
        add_str("99999999999");
        add_str("1+");
        add_str("1)");
        add_str("(1");
        add_str("-7/2");
        add_str("2147483648/0-1");
        add_str("8-3-2");
        add_str("a1b");
        add_str("12 34");
        for (int i = 0; i < 33; i++)
            add_char(CH_OPEN, 1'b0);
        add_char(8'hff, 1'b1);
        for (int i = 0; i < 33; i++)
        begin
            add_num(1);
            add_char(8'h20, 1'b0);
        end
        add_char(8'h00, 1'b1);
        // random part
        n = 0;
        while (items_added < 1900)
        begin
            n++;
            if ($urandom_range(0, 9) < 8)
            begin
                add_expr(0);
                if ($urandom_range(0, 1))
                    add_char(8'h20, 1'b0);
                end_expr();
            end
            else
            begin
                int len;
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    add_char(8'($urandom_range(0, 255)), i == len - 1);
            end
            if (n == 60)
            begin
                while (char_queue.size() > 0) @(posedge clk);
                pause_req = 1'b1;
                while (result_queue.size() > 0 || in_valid) @(posedge clk);
                pause_req = 1'b0;
            end
        end
        while (char_queue.size() > 0 || in_valid) @(posedge clk);
        while (result_queue.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("ran %0d expressions, %0d results checked", exprs_sent, results_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== infix_expression_evaluator_top.f =====
rtl/core/iee_pkg.sv
rtl/core/iee_ram.sv
rtl/core/iee_alu.sv
rtl/core/iee_ctrl.sv
rtl/core/infix_expression_evaluator_top.sv
bench/testbench.sv
